@@ rtl/core/msgenc_pkg.sv @@
// Shared types and constants of the MessagePack item encoder.
`default_nettype none

package msgenc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_NIL      = 3'd0,
      CMD_BOOL     = 3'd1,
      CMD_SINT     = 3'd2,
      CMD_UINT     = 3'd3,
      CMD_ARRAY    = 3'd4,
      CMD_MAP      = 3'd5,
      CMD_STR      = 3'd6,
      CMD_STR_BYTE = 3'd7
   } cmd_type;

   localparam logic [7:0] PFX_NIL    = 8'hC0;
   localparam logic [7:0] PFX_FALSE  = 8'hC2;
   localparam logic [7:0] PFX_TRUE   = 8'hC3;
   localparam logic [7:0] PFX_UINT8  = 8'hCC;
   localparam logic [7:0] PFX_UINT16 = 8'hCD;
   localparam logic [7:0] PFX_UINT32 = 8'hCE;
   localparam logic [7:0] PFX_UINT64 = 8'hCF;
   localparam logic [7:0] PFX_INT8   = 8'hD0;
   localparam logic [7:0] PFX_INT16  = 8'hD1;
   localparam logic [7:0] PFX_INT32  = 8'hD2;
   localparam logic [7:0] PFX_INT64  = 8'hD3;
   localparam logic [7:0] PFX_STR8   = 8'hD9;
   localparam logic [7:0] PFX_STR16  = 8'hDA;
   localparam logic [7:0] PFX_STR32  = 8'hDB;
   localparam logic [7:0] PFX_ARR16  = 8'hDC;
   localparam logic [7:0] PFX_ARR32  = 8'hDD;
   localparam logic [7:0] PFX_MAP16  = 8'hDE;
   localparam logic [7:0] PFX_MAP32  = 8'hDF;
   localparam logic [7:0] FIX_ARRAY  = 8'h90;
   localparam logic [7:0] FIX_MAP    = 8'h80;
   localparam logic [7:0] FIX_STR    = 8'hA0;

   // One classified element: leading byte plus the low nbytes of payload, MSB first.
   typedef struct packed {
      logic [7:0]  prefix;
      logic [63:0] payload;
      logic [3:0]  nbytes;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } q_stat_type;

   typedef struct packed {
      logic busy;
   } bk_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/msgenc_front.sv @@
// Front end: accepts elements and picks the smallest encoding form.
`default_nettype none

module msgenc_front
   import msgenc_pkg::*;
(
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] command
   input  wire q_stat_type  q_stat,
   output logic             q_push,
   output entry_type        q_entry
);

   cmd_type     cmd;
   logic [63:0] v;

   assign cmd        = cmd_type'(req_tuser);
   assign v          = req_tdata;
   assign req_tready = q_stat.not_full;
   assign q_push     = req_tvalid && q_stat.not_full;

   always_comb begin
      q_entry.payload = v;
      q_entry.prefix  = PFX_NIL;
      q_entry.nbytes  = 4'd0;
      unique case (cmd) inside
         CMD_NIL: begin
            q_entry.prefix = PFX_NIL;
         end
         CMD_BOOL: begin
            q_entry.prefix = (v != 64'd0) ? PFX_TRUE : PFX_FALSE;
         end
         CMD_SINT, CMD_UINT: begin
            if (cmd == CMD_SINT && v[63]) begin
               // negative: all bits above the form's width must be ones
               if (&v[63:5]) begin
                  q_entry.prefix = v[7:0];
               end else if (&v[63:7]) begin
                  q_entry.prefix = PFX_INT8;
                  q_entry.nbytes = 4'd1;
               end else if (&v[63:15]) begin
                  q_entry.prefix = PFX_INT16;
                  q_entry.nbytes = 4'd2;
               end else if (&v[63:31]) begin
                  q_entry.prefix = PFX_INT32;
                  q_entry.nbytes = 4'd4;
               end else begin
                  q_entry.prefix = PFX_INT64;
                  q_entry.nbytes = 4'd8;
               end
            end else begin
               if (v[63:7] == '0) begin
                  q_entry.prefix = v[7:0];
               end else if (v[63:8] == '0) begin
                  q_entry.prefix = PFX_UINT8;
                  q_entry.nbytes = 4'd1;
               end else if (v[63:16] == '0) begin
                  q_entry.prefix = PFX_UINT16;
                  q_entry.nbytes = 4'd2;
               end else if (v[63:32] == '0) begin
                  q_entry.prefix = PFX_UINT32;
                  q_entry.nbytes = 4'd4;
               end else begin
                  q_entry.prefix = PFX_UINT64;
                  q_entry.nbytes = 4'd8;
               end
            end
         end
         CMD_ARRAY, CMD_MAP: begin
            // length is the low 32 bits only
            if (v[31:4] == '0) begin
               q_entry.prefix = ((cmd == CMD_ARRAY) ? FIX_ARRAY : FIX_MAP) | {4'd0, v[3:0]};
            end else if (v[31:16] == '0) begin
               q_entry.prefix = (cmd == CMD_ARRAY) ? PFX_ARR16 : PFX_MAP16;
               q_entry.nbytes = 4'd2;
            end else begin
               q_entry.prefix = (cmd == CMD_ARRAY) ? PFX_ARR32 : PFX_MAP32;
               q_entry.nbytes = 4'd4;
            end
         end
         CMD_STR: begin
            if (v[31:5] == '0) begin
               q_entry.prefix = FIX_STR | {3'd0, v[4:0]};
            end else if (v[31:8] == '0) begin
               q_entry.prefix = PFX_STR8;
               q_entry.nbytes = 4'd1;
            end else if (v[31:16] == '0) begin
               q_entry.prefix = PFX_STR16;
               q_entry.nbytes = 4'd2;
            end else begin
               q_entry.prefix = PFX_STR32;
               q_entry.nbytes = 4'd4;
            end
         end
         CMD_STR_BYTE: begin
            q_entry.prefix = v[7:0];
         end
         default: begin
            q_entry.prefix = PFX_NIL;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/msgenc_queue.sv @@
// Short queue of classified elements between front and back.
`default_nettype none

module msgenc_queue
   import msgenc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output entry_type       pop_entry,
   output q_stat_type      stat
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign stat.not_empty = (count_ff != '0);
   assign stat.not_full  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_entry      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/msgenc_back.sv @@
// Back end: serializes one queued element into output bytes.
`default_nettype none

module msgenc_back
   import msgenc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_stat_type q_stat,
   input  wire entry_type  q_entry,
   output logic            q_pop,
   output bk_stat_type     bk_stat,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast
);

   logic [63:0] shift_ff, shift_in;
   logic [3:0]  remain_ff, remain_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        advance;
   logic [2:0]  skip;

   assign advance      = !valid_ff || rsp_tready;
   assign bk_stat.busy = (remain_ff != 4'd0);
   assign q_pop        = advance && !bk_stat.busy && q_stat.not_empty;
   // unused bytes above the payload are shifted out so the first one sits on top
   assign skip         = 3'(4'd8 - q_entry.nbytes);

   always_comb begin
      shift_in  = shift_ff;
      remain_in = remain_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (advance) begin
         if (bk_stat.busy) begin
            byte_in   = shift_ff[63:56];
            last_in   = (remain_ff == 4'd1);
            shift_in  = {shift_ff[55:0], 8'd0};
            remain_in = remain_ff - 4'd1;
            valid_in  = 1'b1;
         end else if (q_stat.not_empty) begin
            byte_in   = q_entry.prefix;
            last_in   = (q_entry.nbytes == 4'd0);
            shift_in  = q_entry.payload << {skip, 3'b000};
            remain_in = q_entry.nbytes;
            valid_in  = 1'b1;
         end else begin
            valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/msgpack_item_encoder.sv @@
// Top level of the MessagePack item encoder: front, queue and serializer.
`default_nettype none

// Takes one MessagePack element per item (command on req_tuser, value on
// req_tdata) and emits its minimal big-endian encoding as a run of bytes on
// rsp_tdata, one byte per cycle while rsp_tready is high, with rsp_tlast on
// the final byte. An element is emitted as 1 to 9 bytes: the leading byte
// plus 0, 1, 2, 4 or 8 payload bytes. The front classifies an element in the
// cycle it is accepted and writes it into a two-entry queue, so items are
// taken in consecutive cycles while the queue has room; with the serializer
// idle, the leading byte is loaded from the queue into the output byte
// register at the same edge that moves the element out of the queue.
// Header lengths use the low 32 bits of value; bool is true for any nonzero
// value; a string body byte is the low 8 bits of value.

module msgpack_item_encoder
   import msgenc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic [2:0]  req_tuser,   // [2:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast
);

   q_stat_type  q_stat;
   bk_stat_type bk_stat;
   entry_type   push_entry;
   entry_type   pop_entry;
   logic        q_push;
   logic        q_pop;

   msgenc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   msgenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .stat       (q_stat)
   );

   msgenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .bk_stat    (bk_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.not_empty)
      else $error("queue popped while empty");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !bk_stat.busy)
      else $error("new element loaded while payload bytes remain");

   a_midrun_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> bk_stat.busy)
      else $error("non-final byte shown with no payload left");

   a_last_frees_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !bk_stat.busy)
      else $error("final byte shown while payload bytes remain");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_msgpack_item_encoder.sv @@
// Self-checking testbench for the MessagePack item encoder.
`timescale 1ns / 100ps

module tb_msgpack_item_encoder;
   import msgenc_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   // Directed element with its encoding typed in (nbytes = 0: use the predictor).
   typedef struct {
      cmd_type     cmd;
      logic [63:0] value;
      int          nbytes;
      logic [71:0] bytes;
   } known_case_type;

   localparam int RANDOM_ITEMS = 245;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [63:0] value
   logic [2:0]  req_tuser;   // [2:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        rsp_tlast;

   enc_byte_type expected_bytes[$];
   int          error_count   = 0;
   int          bytes_checked = 0;
   int          elements_sent = 0;
   int          cmd_count[8];
   bit          hold_off_req  = 1'b0;
   bit          no_idle       = 1'b0;

   msgpack_item_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Minimal-form encoding of one element, appended to expected_bytes.
   function automatic void predict_encoding(input cmd_type cmd, input logic [63:0] value);
      logic [7:0]  lead;
      logic [31:0] len;
      int          n;
      len  = value[31:0];
      n    = 0;
      lead = PFX_NIL;
      case (cmd)
         CMD_NIL: begin
            lead = PFX_NIL;
         end
         CMD_BOOL: begin
            lead = (value != 64'd0) ? PFX_TRUE : PFX_FALSE;
         end
         CMD_SINT, CMD_UINT: begin
            if (cmd == CMD_SINT && value[63]) begin
               if (value >= 64'hFFFF_FFFF_FFFF_FFE0) begin
                  lead = value[7:0];
               end else if (value >= 64'hFFFF_FFFF_FFFF_FF80) begin
                  lead = PFX_INT8;
                  n    = 1;
               end else if (value >= 64'hFFFF_FFFF_FFFF_8000) begin
                  lead = PFX_INT16;
                  n    = 2;
               end else if (value >= 64'hFFFF_FFFF_8000_0000) begin
                  lead = PFX_INT32;
                  n    = 4;
               end else begin
                  lead = PFX_INT64;
                  n    = 8;
               end
            end else if (value <= 64'd127) begin
               lead = value[7:0];
            end else if (value <= 64'hFF) begin
               lead = PFX_UINT8;
               n    = 1;
            end else if (value <= 64'hFFFF) begin
               lead = PFX_UINT16;
               n    = 2;
            end else if (value <= 64'hFFFF_FFFF) begin
               lead = PFX_UINT32;
               n    = 4;
            end else begin
               lead = PFX_UINT64;
               n    = 8;
            end
         end
         CMD_ARRAY, CMD_MAP: begin
            if (len < 32'd16) begin
               lead = ((cmd == CMD_ARRAY) ? FIX_ARRAY : FIX_MAP) | len[7:0];
            end else if (len <= 32'hFFFF) begin
               lead = (cmd == CMD_ARRAY) ? PFX_ARR16 : PFX_MAP16;
               n    = 2;
            end else begin
               lead = (cmd == CMD_ARRAY) ? PFX_ARR32 : PFX_MAP32;
               n    = 4;
            end
         end
         CMD_STR: begin
            if (len < 32'd32) begin
               lead = FIX_STR | len[7:0];
            end else if (len <= 32'hFF) begin
               lead = PFX_STR8;
               n    = 1;
            end else if (len <= 32'hFFFF) begin
               lead = PFX_STR16;
               n    = 2;
            end else begin
               lead = PFX_STR32;
               n    = 4;
            end
         end
         default: begin
            lead = value[7:0];
         end
      endcase
      expected_bytes.push_back('{data: lead, last: (n == 0)});
      // payload goes out most significant byte first, for any length n
      for (int i = n - 1; i >= 0; i--) begin
         expected_bytes.push_back('{data: value[8*i +: 8], last: (i == 0)});
      end
   endfunction

   function automatic known_case_type known(input cmd_type cmd, input logic [63:0] value,
                                            input int nbytes, input logic [71:0] bytes);
      known_case_type c;
      c.cmd    = cmd;
      c.value  = value;
      c.nbytes = nbytes;
      c.bytes  = bytes;
      return c;
   endfunction

   // Random payload biased toward the form boundaries and their negatives.
   function automatic logic [63:0] random_payload();
      logic [63:0] v;
      logic [63:0] marks[8] = '{64'd16, 64'd32, 64'd128, 64'd256, 64'h8000,
                                64'h1_0000, 64'h8000_0000, 64'h1_0000_0000};
      case ($urandom_range(0, 4))
         0: v = {$urandom, $urandom};
         1: v = $urandom_range(0, 300);
         2: begin
            v = marks[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1) == 1) begin
               v = 64'd0 - v;
            end
         end
         3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = ~({$urandom, $urandom} >> $urandom_range(1, 63));
      endcase
      return v;
   endfunction

   // Offer one element from a falling edge and hold it until taken.
   task automatic send_element(input cmd_type cmd, input logic [63:0] value, input int gap,
                               input int nknown, input logic [71:0] kbytes);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (nknown > 0) begin
         for (int i = 0; i < nknown; i++) begin
            expected_bytes.push_back('{data: kbytes[8*(nknown-1-i) +: 8],
                                       last: (i == nknown - 1)});
         end
      end else begin
         predict_encoding(cmd, value);
      end
      elements_sent++;
      cmd_count[int'(cmd)]++;
      @(negedge clock);
   endtask

   // Result side: random stalls per byte, one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            gap          = 150;
            hold_off_req = 1'b0;
         end else if (no_idle) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 19);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : byte_check
      enc_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h arrived with nothing expected", rsp_tdata));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch($sformatf("byte %02h, expected %02h", rsp_tdata, want.data));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("last %b on byte %02h, expected %b",
                                         rsp_tlast, rsp_tdata, want.last));
            end
            bytes_checked++;
         end
      end
   end

   initial begin
      known_case_type table_rows[$];
      cmd_type     cmd;
      int          gap;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 64'd0;
      req_tuser  = CMD_NIL;
      foreach (cmd_count[i]) cmd_count[i] = 0;

      table_rows.push_back(known(CMD_NIL,      64'd0,                   1, 72'hC0));
      table_rows.push_back(known(CMD_BOOL,     64'd0,                   1, 72'hC2));
      table_rows.push_back(known(CMD_BOOL,     64'h8000_0000_0000_0000, 1, 72'hC3));
      table_rows.push_back(known(CMD_UINT,     64'd127,                 1, 72'h7F));
      table_rows.push_back(known(CMD_UINT,     64'd128,                 2, 72'hCC80));
      table_rows.push_back(known(CMD_UINT,     64'hFFFF,                3, 72'hCDFFFF));
      table_rows.push_back(known(CMD_UINT,     64'h1_0000,              5, 72'hCE00010000));
      table_rows.push_back(known(CMD_UINT,     64'hFFFF_FFFF_FFFF_FFFF, 9,
                                 72'hCF_FFFF_FFFF_FFFF_FFFF));
      table_rows.push_back(known(CMD_SINT,     64'hFFFF_FFFF_FFFF_FFFF, 1, 72'hFF));
      table_rows.push_back(known(CMD_SINT,     64'hFFFF_FFFF_FFFF_FFE0, 1, 72'hE0));
      table_rows.push_back(known(CMD_SINT,     64'hFFFF_FFFF_FFFF_FFDF, 2, 72'hD0DF));
      table_rows.push_back(known(CMD_SINT,     64'hFFFF_FFFF_FFFF_FF7F, 3, 72'hD1FF7F));
      table_rows.push_back(known(CMD_SINT,     64'hFFFF_FFFF_FFFF_7FFF, 5, 72'hD2FFFF7FFF));
      table_rows.push_back(known(CMD_SINT,     64'h8000_0000_0000_0000, 9,
                                 72'hD3_8000_0000_0000_0000));
      table_rows.push_back(known(CMD_SINT,     64'd255,                 0, 72'h0));
      table_rows.push_back(known(CMD_SINT,     64'h7FFF_FFFF_FFFF_FFFF, 9,
                                 72'hCF_7FFF_FFFF_FFFF_FFFF));
      table_rows.push_back(known(CMD_ARRAY,    64'd15,                  1, 72'h9F));
      table_rows.push_back(known(CMD_ARRAY,    64'd16,                  3, 72'hDC0010));
      table_rows.push_back(known(CMD_ARRAY,    64'hFFFF_FFFF_0000_0003, 0, 72'h0));
      table_rows.push_back(known(CMD_MAP,      64'h0000_0000_FFFF_FFFF, 5, 72'hDFFFFFFFFF));
      table_rows.push_back(known(CMD_STR,      64'd31,                  1, 72'hBF));
      table_rows.push_back(known(CMD_STR,      64'd32,                  2, 72'hD920));
      table_rows.push_back(known(CMD_STR,      64'h1_0000_0000,         1, 72'hA0));
      table_rows.push_back(known(CMD_STR,      64'd256,                 0, 72'h0));
      table_rows.push_back(known(CMD_STR_BYTE, 64'hFFFF_FFFF_FFFF_FF5A, 1, 72'h5A));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_rows[i]) begin
         send_element(table_rows[i].cmd, table_rows[i].value, $urandom_range(0, 19),
                      table_rows[i].nbytes, table_rows[i].bytes);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 40) begin
            hold_off_req = 1'b1;
         end
         // drain completely before resuming
         if (k == 120) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (expected_bytes.size() != 0);
         end
         no_idle = (k >= 170 && k < 210);
         if (no_idle || (k >= 40 && k < 70)) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 19);
         end
         cmd = cmd_type'($urandom_range(0, 7));
         send_element(cmd, random_payload(), gap, 0, 72'h0);
      end
      req_tvalid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Encoded %0d elements (nil %0d, bool %0d, sint %0d, uint %0d, array %0d,",
               elements_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
               cmd_count[4]);
      $display("  map %0d, str hdr %0d, str byte %0d) into %0d checked bytes, with stalls.",
               cmd_count[5], cmd_count[6], cmd_count[7], bytes_checked);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ msgpack_item_encoder.f @@
rtl/core/msgenc_pkg.sv
rtl/core/msgenc_front.sv
rtl/core/msgenc_queue.sv
rtl/core/msgenc_back.sv
rtl/core/msgpack_item_encoder.sv
tb/sv/tb_msgpack_item_encoder.sv
